FILE: src/rspm_pkg.sv
package rspm_pkg;

	localparam int TEXEL_DEPTH_DEFAULT = 65536;
	localparam int DEST_SIZE_DEFAULT   = 1024;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// widest raw texel address: (511 + 255) * 511 + 255 + 511 < 2**19
	localparam int RAW_ADDR_W = 19;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEST_WIDTH    = 3'd0,
		REG_SOURCE_STRIDE = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_COS_INVERSE   = 3'd4,
		REG_SIN_INVERSE   = 3'd5,
		REG_COLOR_KEY     = 3'd6,
		REG_TINT_COLOR    = 3'd7
	} reg_index_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MAP  = 1'b1
	} opcode_t;

	localparam logic [10:0] DEST_WIDTH_RESET    = 11'd320;
	localparam logic [8:0]  SOURCE_STRIDE_RESET = 9'd128;
	localparam logic [8:0]  SPRITE_WIDTH_RESET  = 9'd16;
	localparam logic [8:0]  SPRITE_HEIGHT_RESET = 9'd16;
	localparam logic [15:0] COS_INVERSE_RESET   = 16'sd256;
	localparam logic [15:0] SIN_INVERSE_RESET   = 16'sd0;
	localparam logic [8:0]  COLOR_NONE          = 9'h1FF;

endpackage

FILE: src/rspm_ram.sv
module rspm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/rotated_sprite_pixel_mapper.sv
// Inverse-maps destination pixels through a signed 8.8 rotation and scale about a
// centre into a sprite held in an 8-bit texel RAM. Load transfers (opcode 0) write
// one texel; map transfers (opcode 1) give at most one (dest_address, pixel_value)
// result: none when the sprite coordinate falls outside the sprite or the texel
// equals the colour key. The block takes one transfer per clock and keeps that rate
// under output stalls as long as a pipeline stage is free; each transfer passes through
// the eight-stage pipeline (products, address multiply, two-stage address wrap, texel
// RAM read) and then the output register. The texel RAM is not cleared at reset: read
// only what was loaded. Configuration writes belong while the pipeline is empty.
module rotated_sprite_pixel_mapper #(
	parameter int TEXEL_DEPTH = rspm_pkg::TEXEL_DEPTH_DEFAULT,
	parameter int DEST_SIZE   = rspm_pkg::DEST_SIZE_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rspm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rspm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [15:0]                         texel_address,
	input  logic [7:0]                          texel_value,
	input  logic [9:0]                          dest_x,
	input  logic [9:0]                          dest_y,
	input  logic signed [18:0]                  center_x_fp,
	input  logic signed [18:0]                  center_y_fp,
	input  logic [7:0]                          sprite_origin_u,
	input  logic [7:0]                          sprite_origin_v,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [19:0]                         dest_address,
	output logic [7:0]                          pixel_value
);

	localparam int RW    = rspm_pkg::RAW_ADDR_W;
	localparam int AW    = $clog2(TEXEL_DEPTH);
	localparam int KTOP  = (AW > RW) ? 0 : RW - AW + 1;
	localparam int KMID  = KTOP / 2;
	localparam int DW    = $clog2(DEST_SIZE);
	localparam int DKTOP = (DW > 10) ? 0 : 10 - DW + 1;

	// wrap modulo the texel depth by conditional subtraction of depth << k
	function automatic logic [RW-1:0] wrap_texel(input logic [RW-1:0] value,
			input int hi, input int lo);
		logic [RW+1:0] acc;
		logic [RW+1:0] step;
		acc = {2'b00, value};
		for (int k = hi; k >= lo; k--) begin
			step = (RW+2)'(longint'(TEXEL_DEPTH) << k);
			if (acc >= step) begin
				acc = acc - step;
			end
		end
		return RW'(acc);
	endfunction

	function automatic logic [9:0] wrap_dest(input logic [9:0] value);
		logic [13:0] acc;
		logic [13:0] step;
		acc = {4'd0, value};
		for (int k = DKTOP; k >= 0; k--) begin
			step = 14'(longint'(DEST_SIZE) << k);
			if (acc >= step) begin
				acc = acc - step;
			end
		end
		return 10'(acc);
	endfunction

	// configuration registers
	logic [10:0]        dest_width_q;
	logic [8:0]         source_stride_q;
	logic [8:0]         sprite_width_q;
	logic [8:0]         sprite_height_q;
	logic signed [15:0] cos_inverse_q;
	logic signed [15:0] sin_inverse_q;
	logic [8:0]         color_key_q;
	logic [8:0]         tint_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q    <= rspm_pkg::DEST_WIDTH_RESET;
			source_stride_q <= rspm_pkg::SOURCE_STRIDE_RESET;
			sprite_width_q  <= rspm_pkg::SPRITE_WIDTH_RESET;
			sprite_height_q <= rspm_pkg::SPRITE_HEIGHT_RESET;
			cos_inverse_q   <= rspm_pkg::COS_INVERSE_RESET;
			sin_inverse_q   <= rspm_pkg::SIN_INVERSE_RESET;
			color_key_q     <= rspm_pkg::COLOR_NONE;
			tint_color_q    <= rspm_pkg::COLOR_NONE;
		end else if (cfg_write) begin
			case (rspm_pkg::reg_index_t'(cfg_index))
				rspm_pkg::REG_DEST_WIDTH:    dest_width_q    <= cfg_data[10:0];
				rspm_pkg::REG_SOURCE_STRIDE: source_stride_q <= cfg_data[8:0];
				rspm_pkg::REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data[8:0];
				rspm_pkg::REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data[8:0];
				rspm_pkg::REG_COS_INVERSE:   cos_inverse_q   <= cfg_data;
				rspm_pkg::REG_SIN_INVERSE:   sin_inverse_q   <= cfg_data;
				rspm_pkg::REG_COLOR_KEY:     color_key_q     <= cfg_data[8:0];
				rspm_pkg::REG_TINT_COLOR:    tint_color_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// pipeline valids and stage enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_out;
	logic out_valid_q;

	assign en_out = !out_valid_q || out_ready;
	assign en_s8  = !valid_s8 || en_out;
	assign en_s7  = !valid_s7 || en_s8;
	assign en_s6  = !valid_s6 || en_s7;
	assign en_s5  = !valid_s5 || en_s6;
	assign en_s4  = !valid_s4 || en_s5;
	assign en_s3  = !valid_s3 || en_s4;
	assign en_s2  = !valid_s2 || en_s3;
	assign en_s1  = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
		end
	end

	// stage 1: capture, wrap destination coordinates
	logic               map_s1;
	logic [9:0]         dx_s1, dy_s1;
	logic signed [18:0] cx_s1, cy_s1;
	logic [7:0]         orig_u_s1, orig_v_s1;
	logic [15:0]        load_addr_s1;
	logic [7:0]         load_data_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			map_s1       <= (rspm_pkg::opcode_t'(opcode) == rspm_pkg::OP_MAP);
			dx_s1        <= wrap_dest(dest_x);
			dy_s1        <= wrap_dest(dest_y);
			cx_s1        <= center_x_fp;
			cy_s1        <= center_y_fp;
			orig_u_s1    <= sprite_origin_u;
			orig_v_s1    <= sprite_origin_v;
			load_addr_s1 <= texel_address;
			load_data_s1 <= texel_value;
		end
	end

	// stage 2: offsets from the centre
	logic               map_s2;
	logic [9:0]         dx_s2, dy_s2;
	logic signed [20:0] ex_s2, ey_s2;
	logic [7:0]         orig_u_s2, orig_v_s2;
	logic [15:0]        load_addr_s2;
	logic [7:0]         load_data_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			map_s2       <= map_s1;
			dx_s2        <= dx_s1;
			dy_s2        <= dy_s1;
			ex_s2        <= $signed({3'b000, dx_s1, 8'h00}) - {{2{cx_s1[18]}}, cx_s1};
			ey_s2        <= $signed({3'b000, dy_s1, 8'h00}) - {{2{cy_s1[18]}}, cy_s1};
			orig_u_s2    <= orig_u_s1;
			orig_v_s2    <= orig_v_s1;
			load_addr_s2 <= load_addr_s1;
			load_data_s2 <= load_data_s1;
		end
	end

	// stage 3: rotation products and destination address
	logic signed [36:0] prod_xc, prod_ys, prod_xs, prod_yc;
	logic               map_s3;
	logic signed [36:0] prod_xc_s3, prod_ys_s3, prod_xs_s3, prod_yc_s3;
	logic [19:0]        daddr_s3;
	logic [7:0]         orig_u_s3, orig_v_s3;
	logic [15:0]        load_addr_s3;
	logic [7:0]         load_data_s3;

	assign prod_xc = ex_s2 * cos_inverse_q;
	assign prod_ys = ey_s2 * sin_inverse_q;
	assign prod_xs = ex_s2 * sin_inverse_q;
	assign prod_yc = ey_s2 * cos_inverse_q;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			map_s3       <= map_s2;
			prod_xc_s3   <= prod_xc;
			prod_ys_s3   <= prod_ys;
			prod_xs_s3   <= prod_xs;
			prod_yc_s3   <= prod_yc;
			daddr_s3     <= 20'(dy_s2) * 20'(dest_width_q) + 20'(dx_s2);
			orig_u_s3    <= orig_u_s2;
			orig_v_s3    <= orig_v_s2;
			load_addr_s3 <= load_addr_s2;
			load_data_s3 <= load_data_s2;
		end
	end

	// stage 4: floor to sprite coordinate, bounds check
	logic signed [28:0] fl_xc, fl_ys, fl_xs, fl_yc;
	logic signed [30:0] sx_fp, sy_fp;
	logic [22:0]        sx_int, sy_int;
	logic               in_sprite;
	logic               map_s4, hit_s4;
	logic [8:0]         sx_s4, sy_s4;
	logic [19:0]        daddr_s4;
	logic [7:0]         orig_u_s4, orig_v_s4;
	logic [15:0]        load_addr_s4;
	logic [7:0]         load_data_s4;

	assign fl_xc = prod_xc_s3[36:8];
	assign fl_ys = prod_ys_s3[36:8];
	assign fl_xs = prod_xs_s3[36:8];
	assign fl_yc = prod_yc_s3[36:8];
	assign sx_fp = {{2{fl_xc[28]}}, fl_xc} - {{2{fl_ys[28]}}, fl_ys}
		+ $signed({15'd0, sprite_width_q, 7'd0});
	assign sy_fp = {{2{fl_xs[28]}}, fl_xs} + {{2{fl_yc[28]}}, fl_yc}
		+ $signed({15'd0, sprite_height_q, 7'd0});
	assign sx_int = sx_fp[30:8];
	assign sy_int = sy_fp[30:8];
	assign in_sprite = !sx_int[22] && !sy_int[22]
		&& (sx_int[21:0] < {13'd0, sprite_width_q})
		&& (sy_int[21:0] < {13'd0, sprite_height_q});

	always_ff @(posedge clk) begin
		if (en_s4) begin
			map_s4       <= map_s3;
			hit_s4       <= map_s3 && in_sprite;
			sx_s4        <= sx_int[8:0];
			sy_s4        <= sy_int[8:0];
			daddr_s4     <= daddr_s3;
			orig_u_s4    <= orig_u_s3;
			orig_v_s4    <= orig_v_s3;
			load_addr_s4 <= load_addr_s3;
			load_data_s4 <= load_data_s3;
		end
	end

	// stage 5: raw texel address
	logic [9:0]    row_sum;
	logic [RW-1:0] raw_map;
	logic          map_s5, hit_s5;
	logic [RW-1:0] raw_s5;
	logic [19:0]   daddr_s5;
	logic [7:0]    load_data_s5;

	assign row_sum = 10'(sy_s4) + 10'(orig_v_s4);
	assign raw_map = RW'(row_sum) * RW'(source_stride_q) + RW'(orig_u_s4) + RW'(sx_s4);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			map_s5       <= map_s4;
			hit_s5       <= hit_s4;
			raw_s5       <= map_s4 ? raw_map : RW'(load_addr_s4);
			daddr_s5     <= daddr_s4;
			load_data_s5 <= load_data_s4;
		end
	end

	// stages 6 and 7: wrap to texel depth
	logic          map_s6, hit_s6;
	logic [RW-1:0] raw_s6;
	logic [19:0]   daddr_s6;
	logic [7:0]    load_data_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			map_s6       <= map_s5;
			hit_s6       <= hit_s5;
			raw_s6       <= wrap_texel(raw_s5, KTOP, KMID + 1);
			daddr_s6     <= daddr_s5;
			load_data_s6 <= load_data_s5;
		end
	end

	logic          map_s7, hit_s7;
	logic [AW-1:0] addr_s7;
	logic [19:0]   daddr_s7;
	logic [7:0]    load_data_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			map_s7       <= map_s6;
			hit_s7       <= hit_s6;
			addr_s7      <= AW'(wrap_texel(raw_s6, KMID, 0));
			daddr_s7     <= daddr_s6;
			load_data_s7 <= load_data_s6;
		end
	end

	// stage 8: texel RAM access, write for loads and read for maps in order
	logic       hit_s8;
	logic [19:0] daddr_s8;
	logic [7:0] texel;

	rspm_ram #(
		.WIDTH (8),
		.DEPTH (TEXEL_DEPTH)
	) u_texel_ram (
		.clk   (clk),
		.we    (en_s8 && valid_s7 && !map_s7),
		.waddr (addr_s7),
		.wdata (load_data_s7),
		.re    (en_s8),
		.raddr (addr_s7),
		.rdata (texel)
	);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			hit_s8   <= hit_s7;
			daddr_s8 <= daddr_s7;
		end
	end

	// output register: key test and tint
	logic       keyed;
	logic [7:0] dest_pixel;
	logic [19:0] dest_address_q;
	logic [7:0] pixel_value_q;

	assign keyed      = !color_key_q[8] && (texel == color_key_q[7:0]);
	assign dest_pixel = (tint_color_q == rspm_pkg::COLOR_NONE) ? texel : tint_color_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s8 && hit_s8 && !keyed;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			dest_address_q <= daddr_s8;
			pixel_value_q  <= dest_pixel;
		end
	end

	assign out_valid    = out_valid_q;
	assign dest_address = dest_address_q;
	assign pixel_value  = pixel_value_q;

endmodule
